FILE: hw/rtl/tspd_pkg.sv
package tspd_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned EchoW  = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] REG_NEAR_LIMIT  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_FLOOR_LIMIT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_QUIET_TIME  = 2'd2;

  // reset values: 5 cm and 1 cm at 58 us per cm, 300 ms quiet time
  localparam logic [EchoW-1:0] NEAR_LIMIT_RST  = 16'd290;
  localparam logic [EchoW-1:0] FLOOR_LIMIT_RST = 16'd58;
  localparam logic [TimeW-1:0] QUIET_TIME_RST  = 32'd300000;

  typedef struct packed {
    logic [TimeW-1:0] now_us;
    logic             echo_a_valid;
    logic [EchoW-1:0] echo_a_us;
    logic             echo_b_valid;
    logic [EchoW-1:0] echo_b_us;
  } item_t;

  typedef struct packed {
    logic [EchoW-1:0] near_limit_us;
    logic [EchoW-1:0] floor_limit_us;
    logic [TimeW-1:0] quiet_time_us;
  } cfg_t;

  // decision of the tracker for the item in the input register
  typedef struct packed {
    logic emit;
    logic direction;
  } verdict_t;

endpackage

FILE: hw/rtl/tspd_if.sv
interface tspd_sample_if;
  import tspd_pkg::*;

  logic             valid;
  logic             ready;
  logic [TimeW-1:0] now_us;
  logic             echo_a_valid;
  logic [EchoW-1:0] echo_a_us;
  logic             echo_b_valid;
  logic [EchoW-1:0] echo_b_us;

  modport source (
    output valid, now_us, echo_a_valid, echo_a_us, echo_b_valid, echo_b_us,
    input  ready
  );
  modport sink (
    input  valid, now_us, echo_a_valid, echo_a_us, echo_b_valid, echo_b_us,
    output ready
  );
endinterface

interface tspd_passage_if;
  logic valid;
  logic ready;
  logic direction;

  modport source (output valid, direction, input ready);
  modport sink (input valid, direction, output ready);
endinterface

FILE: hw/rtl/tspd_cfg_regs.sv
module tspd_cfg_regs
  import tspd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.near_limit_us  <= NEAR_LIMIT_RST;
      cfg.floor_limit_us <= FLOOR_LIMIT_RST;
      cfg.quiet_time_us  <= QUIET_TIME_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_NEAR_LIMIT:  cfg.near_limit_us  <= cfg_data[EchoW-1:0];
        REG_FLOOR_LIMIT: cfg.floor_limit_us <= cfg_data[EchoW-1:0];
        REG_QUIET_TIME:  cfg.quiet_time_us  <= cfg_data[TimeW-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/tspd_track.sv
module tspd_track
  import tspd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  item_t    item,
  input  logic     step,
  output verdict_t verdict
);

  logic [EchoW-1:0] last_echo_a, last_echo_b;
  logic [TimeW-1:0] near_time_a, near_time_b;
  logic             moved_a, moved_b;

  logic [EchoW-1:0] last_echo_a_next, last_echo_b_next;
  logic [TimeW-1:0] near_time_a_next, near_time_b_next;
  logic             moved_a_next, moved_b_next;
  logic [TimeW-1:0] age_a, age_b;
  logic             far_both;

  always_comb begin
    last_echo_a_next = item.echo_a_valid ? item.echo_a_us : last_echo_a;
    last_echo_b_next = item.echo_b_valid ? item.echo_b_us : last_echo_b;

    near_time_a_next = (item.echo_a_valid && item.echo_a_us <= cfg.near_limit_us)
                       ? item.now_us : near_time_a;
    near_time_b_next = (item.echo_b_valid && item.echo_b_us <= cfg.near_limit_us)
                       ? item.now_us : near_time_b;

    // movement band is open at both ends
    moved_a_next = moved_a || (last_echo_a_next < cfg.near_limit_us &&
                               last_echo_a_next > cfg.floor_limit_us);
    moved_b_next = moved_b || (last_echo_b_next < cfg.near_limit_us &&
                               last_echo_b_next > cfg.floor_limit_us);

    // wrapping age of each near time
    age_a = item.now_us - near_time_a_next;
    age_b = item.now_us - near_time_b_next;

    far_both = last_echo_a_next > cfg.near_limit_us &&
               last_echo_b_next > cfg.near_limit_us;

    verdict.emit = far_both && (moved_a_next || moved_b_next) &&
                   age_a > cfg.quiet_time_us && age_b > cfg.quiet_time_us;
    // a reached near first (or together) means exit
    verdict.direction = near_time_a_next <= near_time_b_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_echo_a <= '0;
      last_echo_b <= '0;
      near_time_a <= '0;
      near_time_b <= '0;
      moved_a     <= 1'b0;
      moved_b     <= 1'b0;
    end else if (step) begin
      last_echo_a <= last_echo_a_next;
      last_echo_b <= last_echo_b_next;
      near_time_a <= near_time_a_next;
      near_time_b <= near_time_b_next;
      moved_a     <= moved_a_next && !verdict.emit;
      moved_b     <= moved_b_next && !verdict.emit;
    end
  end

endmodule

FILE: hw/rtl/two_sensor_passage_direction_core.sv
// path: an accepted sample transaction passes the input register, then the result
//   register, before its passage result shows; the held sample may wait in between
// throughput: one sample per cycle; the held sample waits only while it would
//   produce a result and an untaken passage transaction still occupies the result register
// reset: synchronous, active high; clears both registers' valid flags,
//   the tracker state and the configuration registers to their defaults
module two_sensor_passage_direction_core
  import tspd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  tspd_sample_if.sink         sample,
  tspd_passage_if.source      passage,
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t     cfg;
  verdict_t verdict;

  // input register
  logic  hold_valid;
  item_t hold_item;

  // result register
  logic out_valid;
  logic out_direction;

  logic step;

  tspd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // tracker state advances exactly when the held sample moves on
  tspd_track u_track (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .item    (hold_item),
    .step    (step),
    .verdict (verdict)
  );

  // the held sample only waits when it would produce a result and the
  // result register is still occupied by an untaken transaction
  assign step = hold_valid && !(verdict.emit && out_valid && !passage.ready);

  // the input register frees up whenever the held sample moves on
  assign sample.ready = !hold_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (sample.ready) begin
      hold_valid <= sample.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      hold_item.now_us       <= sample.now_us;
      hold_item.echo_a_valid <= sample.echo_a_valid;
      hold_item.echo_a_us    <= sample.echo_a_us;
      hold_item.echo_b_valid <= sample.echo_b_valid;
      hold_item.echo_b_us    <= sample.echo_b_us;
    end
  end

  // result register: loaded on a decision, emptied when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && verdict.emit) begin
      out_valid <= 1'b1;
    end else if (passage.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && verdict.emit) begin
      out_direction <= verdict.direction;
    end
  end

  assign passage.valid     = out_valid;
  assign passage.direction = out_direction;

endmodule

FILE: hw/rtl/tspd_checker.sv
module tspd_checker (
  input logic clk,
  input logic rst,
  input logic sample_valid,
  input logic sample_ready,
  input logic passage_valid,
  input logic passage_ready,
  input logic passage_direction
);

  // a pending passage transaction stays until taken
  assert property (@(posedge clk) disable iff (rst)
    passage_valid && !passage_ready |=> passage_valid)
    else $error("passage dropped while stalled");

  // its direction holds while stalled
  assert property (@(posedge clk) disable iff (rst)
    passage_valid && !passage_ready |=> $stable(passage_direction))
    else $error("passage direction changed while stalled");

  // nothing comes out straight after reset
  assert property (@(posedge clk) rst |=> !passage_valid)
    else $error("passage valid after reset");

  // a fresh result always stems from a sample that went into the input register and moved straight on
  assert property (@(posedge clk) disable iff (rst)
    $rose(passage_valid) |-> $past(sample_valid && sample_ready, 2))
    else $error("passage without matching sample");

endmodule

bind two_sensor_passage_direction_core tspd_checker u_tspd_checker (
  .clk               (clk),
  .rst               (rst),
  .sample_valid      (sample.valid),
  .sample_ready      (sample.ready),
  .passage_valid     (passage.valid),
  .passage_ready     (passage.ready),
  .passage_direction (passage.direction)
);
